@@ sv/samarc_pkg.sv @@
package samarc_pkg;

  // default sizes
  localparam int unsigned NUM_ASSOC_DEF  = 8;
  localparam int unsigned REPLAY_WIN_DEF = 64;

  // protocol constants
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] IP_MIN_BYTES   = 16'd20;
  localparam logic [6:0]  UDP_HDR_BYTES  = 7'd8;
  localparam logic [7:0]  SEQ_BYTES      = 8'd8;
  localparam logic [7:0]  AUTH_TAG_BYTES = 8'd16;

  // slot field reaches at most this many slots
  localparam int unsigned SLOT_FIELD_SLOTS = 8;

  // operation codes
  typedef enum logic {
    OP_PACKET  = 1'b0,
    OP_INSTALL = 1'b1
  } op_e;

  // result verdicts
  typedef enum logic [2:0] {
    VERDICT_PASS      = 3'd0,
    VERDICT_SHORT     = 3'd1,
    VERDICT_REPLAY    = 3'd2,
    VERDICT_ACCEPT    = 3'd3,
    VERDICT_INSTALLED = 3'd4
  } verdict_e;

endpackage

@@ sv/samarc_window.sv @@
module samarc_window #(
  parameter int unsigned WINDOW_BITS = 64
) (
  input  logic [63:0]            top_i,
  input  logic [WINDOW_BITS-1:0] bitmap_i,
  input  logic [63:0]            seq_i,
  output logic                   accept_o,
  output logic [63:0]            top_o,
  output logic [WINDOW_BITS-1:0] bitmap_o
);
  import samarc_pkg::*;

  localparam int unsigned ShW = $clog2(WINDOW_BITS);

  logic        newer;
  logic [63:0] diff;
  logic [63:0] off;
  logic        off_in_win;
  logic        off_seen;

  // distances in both directions from the current top
  assign newer      = seq_i > top_i;
  assign diff       = seq_i - top_i;
  assign off        = top_i - seq_i;
  assign off_in_win = off < 64'(WINDOW_BITS);
  assign off_seen   = off_in_win && bitmap_i[off[ShW-1:0]];

  // slide the window or mark an older number as seen
  always_comb begin
    accept_o = 1'b0;
    top_o    = top_i;
    bitmap_o = bitmap_i;
    if (newer) begin
      accept_o = 1'b1;
      top_o    = seq_i;
      if (diff >= 64'(WINDOW_BITS)) begin
        bitmap_o = WINDOW_BITS'(1);
      end else begin
        bitmap_o = (bitmap_i << diff[ShW-1:0]) | WINDOW_BITS'(1);
      end
    end else if (off_in_win && !off_seen) begin
      accept_o = 1'b1;
      bitmap_o = bitmap_i | (WINDOW_BITS'(1) << off[ShW-1:0]);
    end
  end

endmodule

@@ sv/sa_match_and_anti_replay_check_core.sv @@
// channel | valid      | stall       | payload
// --------+------------+-------------+--------------------------------------------
// in      | in_valid_i | in_stall_o  | op, slot, mark, peer_ip, dst_port, protocol,
//         |            |             | header_words, packet_length, seq
// out     | out_valid_o| out_stall_i | verdict, matched_slot
//
// one transaction per cycle unless the output stalls; input register, then result
// register; lookup, window check and state update act on the input register as it
// fires, so the next transaction sees the updated association state
// reset clears valid bits and all replay state at once; no clearing pass
// a stalled result holds the result register and stalls the input register
module sa_match_and_anti_replay_check_core #(
  parameter int unsigned NUM_ASSOC   = samarc_pkg::NUM_ASSOC_DEF,
  parameter int unsigned WINDOW_BITS = samarc_pkg::REPLAY_WIN_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 op_i,
  input  logic [2:0]           slot_i,
  input  logic [31:0]          mark_i,
  input  logic [31:0]          peer_ip_i,
  input  logic [15:0]          dst_port_i,
  input  logic [7:0]           protocol_i,
  input  logic [3:0]           header_words_i,
  input  logic [15:0]          packet_length_i,
  input  logic [63:0]          seq_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output samarc_pkg::verdict_e verdict_o,
  output logic [2:0]           matched_slot_o
);
  import samarc_pkg::*;

  // slots beyond the slot field can never be installed, so they are not built
  localparam int unsigned NumSlots =
    (NUM_ASSOC < SLOT_FIELD_SLOTS) ? NUM_ASSOC : SLOT_FIELD_SLOTS;
  localparam int unsigned SlotW = (NumSlots > 1) ? $clog2(NumSlots) : 1;

  // input register
  logic        in_valid_q;
  logic        op_q;
  logic [2:0]  slot_q;
  logic [31:0] mark_q;
  logic [31:0] peer_q;
  logic [15:0] port_q;
  logic [7:0]  proto_q;
  logic [3:0]  hwords_q;
  logic [15:0] plen_q;
  logic [63:0] seq_q;

  // association table
  logic [NumSlots-1:0]    slot_valid_q;
  logic [31:0]            assoc_mark_q  [NumSlots];
  logic [31:0]            assoc_peer_q  [NumSlots];
  logic [15:0]            assoc_port_q  [NumSlots];
  logic [63:0]            highest_seq_q [NumSlots];
  logic [WINDOW_BITS-1:0] bitmap_q      [NumSlots];

  // result register
  logic       res_valid_q;
  verdict_e   verdict_q, verdict_d;
  logic [2:0] mslot_q, mslot_d;

  logic advance;
  logic fire;

  // handshake
  assign advance    = !res_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      op_q     <= op_i;
      slot_q   <= slot_i;
      mark_q   <= mark_i;
      peer_q   <= peer_ip_i;
      port_q   <= dst_port_i;
      proto_q  <= protocol_i;
      hwords_q <= header_words_i;
      plen_q   <= packet_length_i;
      seq_q    <= seq_i;
    end
  end

  // length and protocol checks
  logic [6:0]  hdr_end;
  logic [7:0]  min_len;
  logic        is_udp_ok;
  logic        payload_short;

  assign hdr_end       = {1'b0, hwords_q, 2'b00} + UDP_HDR_BYTES;
  assign is_udp_ok     = (plen_q >= IP_MIN_BYTES) && (proto_q == PROTO_UDP) &&
                         (plen_q >= 16'(hdr_end));
  assign min_len       = 8'(hdr_end) + SEQ_BYTES + AUTH_TAG_BYTES;
  assign payload_short = plen_q < 16'(min_len);

  // parallel slot compare
  logic [NumSlots-1:0] mark_hit;
  logic [NumSlots-1:0] peer_hit;
  logic [NumSlots-1:0] use_hit;
  logic                found;
  logic [SlotW-1:0]    idx;

  always_comb begin
    for (int i = 0; i < NumSlots; i++) begin
      mark_hit[i] = slot_valid_q[i] && (assoc_mark_q[i] == mark_q);
      peer_hit[i] = slot_valid_q[i] && (assoc_peer_q[i] == peer_q) &&
                    (assoc_port_q[i] == port_q);
    end
    use_hit = ((mark_q != 32'd0) && (|mark_hit)) ? mark_hit : peer_hit;
    found   = |use_hit;
  end

  // lowest slot wins
  always_comb begin
    idx = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (use_hit[i]) begin
        idx = SlotW'(i);
      end
    end
  end

  // replay window on the matched slot
  logic                   win_accept;
  logic [63:0]            win_top;
  logic [WINDOW_BITS-1:0] win_bitmap;

  samarc_window #(
    .WINDOW_BITS(WINDOW_BITS)
  ) u_window (
    .top_i   (highest_seq_q[idx]),
    .bitmap_i(bitmap_q[idx]),
    .seq_i   (seq_q),
    .accept_o(win_accept),
    .top_o   (win_top),
    .bitmap_o(win_bitmap)
  );

  logic do_install;
  logic do_window;

  assign do_install = fire && (op_q == OP_INSTALL) && ({1'b0, slot_q} < 4'(NumSlots));
  assign do_window  = fire && (op_q == OP_PACKET) && is_udp_ok && found && !payload_short;

  // verdict selection
  always_comb begin
    verdict_d = VERDICT_PASS;
    mslot_d   = 3'd0;
    if (op_q == OP_INSTALL) begin
      verdict_d = VERDICT_INSTALLED;
      mslot_d   = slot_q;
    end else if (is_udp_ok && found) begin
      mslot_d = 3'(idx);
      if (payload_short) begin
        verdict_d = VERDICT_SHORT;
      end else if (win_accept) begin
        verdict_d = VERDICT_ACCEPT;
      end else begin
        verdict_d = VERDICT_REPLAY;
      end
    end
  end

  // association valid bits and replay state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      for (int i = 0; i < NumSlots; i++) begin
        highest_seq_q[i] <= '0;
        bitmap_q[i]      <= '0;
      end
    end else if (do_install) begin
      slot_valid_q[slot_q[SlotW-1:0]]  <= 1'b1;
      highest_seq_q[slot_q[SlotW-1:0]] <= '0;
      bitmap_q[slot_q[SlotW-1:0]]      <= '0;
    end else if (do_window && win_accept) begin
      highest_seq_q[idx] <= win_top;
      bitmap_q[idx]      <= win_bitmap;
    end
  end

  // association keys
  always_ff @(posedge clk_i) begin
    if (do_install) begin
      assoc_mark_q[slot_q[SlotW-1:0]] <= mark_q;
      assoc_peer_q[slot_q[SlotW-1:0]] <= peer_q;
      assoc_port_q[slot_q[SlotW-1:0]] <= port_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      verdict_q <= verdict_d;
      mslot_q   <= mslot_d;
    end
  end

  assign out_valid_o    = res_valid_q;
  assign verdict_o      = verdict_q;
  assign matched_slot_o = mslot_q;

  // input side stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  // an install leaves its slot valid
  a_install_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_install |=> slot_valid_q[$past(slot_q[SlotW-1:0])])
    else $error("installed slot not valid");

  // a newer accepted number becomes the slot top
  a_top_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_window && win_accept && !do_install) |=> highest_seq_q[$past(idx)] == $past(win_top))
    else $error("window top not updated");

  // pass through results carry no slot
  a_pass_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (verdict_o == VERDICT_PASS)) |-> (matched_slot_o == 3'd0))
    else $error("pass through with a slot");

endmodule
